/* hw/rtl/array_list_engine_top_defines.svh */
// Assertion macros shared by the array list engine checker.
`ifndef ARRAY_LIST_ENGINE_TOP_DEFINES_SVH
`define ARRAY_LIST_ENGINE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, quiet during reset.
`define ALE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock, quiet during reset.
`define ALE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/ale_pkg.sv */
// Package of the array list engine: sizes, operation codes and sequencer states.
`default_nettype none

package ale_pkg;

	localparam int DEPTH   = 64;
	localparam int ADDR_W  = $clog2(DEPTH);
	// Capacity is a 7-bit register, so the usable size never exceeds 127.
	localparam int CAP_MAX = (DEPTH > 127) ? 127 : DEPTH;
	localparam logic [6:0] CAP_MAX_C = 7'(CAP_MAX);

	localparam int DATA_W = 32;
	localparam int POS_W  = 7;
	localparam int PADDR_W = 3;

	localparam logic REG_CAPACITY = 1'b0;

	typedef enum logic [2:0] {
		OP_INSERT_AT    = 3'd0,
		OP_INSERT_START = 3'd1,
		OP_APPEND       = 3'd2,
		OP_SEARCH       = 3'd3,
		OP_READ         = 3'd4,
		OP_REMOVE       = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_WALK_DOWN,
		S_PUT,
		S_WALK_UP,
		S_DONE
	} state_t;

	function automatic logic [ADDR_W-1:0] to_addr(input logic [POS_W-1:0] x);
		return ADDR_W'(x);
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/array_list_engine_top.sv */
// Top level of the array list engine: list store, sequencer and register port.
//
// The engine keeps an ordered list of signed 32-bit values in a single synchronous RAM with one
// write and one read port, plus an entry count, and takes one command beat at a time. Every
// command passes through decode and then hands over its result. An insert at zero-based slot t
// of a list of n entries moves n-t entries, one per cycle through the RAM read-then-write
// pipeline. Remove at slot t reads n-t entries. A search reads from slot 0 until the first match.
// A new command is taken while the previous result still waits in the output register.
// Writing the capacity register (byte address 0) empties the list; the stored value 0
// acts as 1 and values above the store depth act as the depth. The RAM needs no clearing pass.
`default_nettype none

module array_list_engine_top (
	input  wire                          clk,
	input  wire                          arst_n,
	// Command channel.
	input  wire                          item_valid,
	output logic                         item_ready,
	input  wire  [2:0]                   operation,
	input  wire  signed [ale_pkg::DATA_W-1:0] item_value,
	input  wire  [ale_pkg::POS_W-1:0]    position,
	// Result channel.
	output logic                         result_valid,
	input  wire                          result_ready,
	output logic                         ok,
	output logic signed [ale_pkg::DATA_W-1:0] value_out,
	output logic [ale_pkg::POS_W-1:0]    found_position,
	output logic [ale_pkg::POS_W-1:0]    count_out,
	// Register port.
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire  [ale_pkg::PADDR_W-1:0]  paddr,
	input  wire  [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import ale_pkg::*;

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_s1;

	state_t state_q, state_nx;

	logic [2:0]        op_q;
	logic [DATA_W-1:0] val_q;
	logic [POS_W-1:0]  pos_q;
	logic [POS_W-1:0]  cnt_q;
	logic [POS_W-1:0]  cap_q;

	logic [POS_W-1:0]  tgt_q;
	logic [POS_W-1:0]  idx_q;
	logic [POS_W-1:0]  end_q;
	logic [POS_W-1:0]  src_q;
	logic              more_q;
	logic              pend_q;

	logic              r_ok_q;
	logic [DATA_W-1:0] r_val_q;
	logic [POS_W-1:0]  r_fpos_q;

	logic              out_valid_q;
	logic              out_ok_q;
	logic [DATA_W-1:0] out_val_q;
	logic [POS_W-1:0]  out_fpos_q;
	logic [POS_W-1:0]  out_cnt_q;

	// Decode results.
	logic [POS_W-1:0]  cap_u;
	logic              full;
	logic              pos_in;
	logic              dec_ins;
	logic              dec_walk;
	logic [POS_W-1:0]  dec_tgt;
	logic [POS_W-1:0]  dec_start;
	logic [POS_W-1:0]  dec_stop;

	// RAM controls.
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [DATA_W-1:0] wr_data;

	logic              walk_end;
	logic              hit;
	logic              cfg_wr;
	logic              out_load;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);
	assign prdata = (paddr[2] == REG_CAPACITY) ? {25'd0, cap_q} : 32'd0;

	assign item_ready     = (state_q == S_IDLE);
	assign result_valid   = out_valid_q;
	assign ok             = out_ok_q;
	assign value_out      = out_val_q;
	assign found_position = out_fpos_q;
	assign count_out      = out_cnt_q;

	assign walk_end = !more_q && !pend_q;
	assign hit      = pend_q && (rdata_s1 == val_q);
	assign out_load = (state_q == S_DONE) && (!out_valid_q || result_ready);

	always_comb begin
		if (cap_q == 7'd0) begin
			cap_u = 7'd1;
		end else if (cap_q > CAP_MAX_C) begin
			cap_u = CAP_MAX_C;
		end else begin
			cap_u = cap_q;
		end
	end

	always_comb begin
		full      = (cnt_q >= cap_u);
		pos_in    = (pos_q != 7'd0) && (pos_q <= cnt_q);
		dec_ins   = 1'b0;
		dec_walk  = 1'b0;
		dec_tgt   = 7'd0;
		dec_start = 7'd0;
		dec_stop  = 7'd0;
		case (op_q)
			OP_INSERT_AT: begin
				if (!full) begin
					if (cnt_q == 7'd0) begin
						dec_ins = 1'b1;
					end else if (pos_in) begin
						dec_ins = 1'b1;
						dec_tgt = pos_q - 7'd1;
					end else if ((pos_q > cnt_q) &&
							({1'b0, pos_q} <= {1'b0, cap_u} + 8'd1)) begin
						// Past the end but within capacity plus one: append.
						dec_ins = 1'b1;
						dec_tgt = cnt_q;
					end
				end
			end
			OP_INSERT_START: begin
				dec_ins = !full;
			end
			OP_APPEND: begin
				dec_ins = !full;
				dec_tgt = cnt_q;
			end
			OP_SEARCH: begin
				dec_walk = (cnt_q != 7'd0);
				dec_stop = cnt_q - 7'd1;
			end
			OP_READ: begin
				dec_walk  = pos_in;
				dec_tgt   = pos_q - 7'd1;
				dec_start = pos_q - 7'd1;
				dec_stop  = pos_q - 7'd1;
			end
			OP_REMOVE: begin
				dec_walk  = pos_in;
				dec_tgt   = pos_q - 7'd1;
				dec_start = pos_q - 7'd1;
				dec_stop  = cnt_q - 7'd1;
			end
			default: begin
			end
		endcase
		// Shifting up for an insert walks from the last entry down to the target.
		if (dec_ins) begin
			dec_start = cnt_q - 7'd1;
			dec_stop  = dec_tgt;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					state_nx = S_DECODE;
				end
			end
			S_DECODE: begin
				if (dec_ins) begin
					state_nx = (dec_tgt == cnt_q) ? S_PUT : S_WALK_DOWN;
				end else if (dec_walk) begin
					state_nx = S_WALK_UP;
				end else begin
					state_nx = S_DONE;
				end
			end
			S_WALK_DOWN: begin
				if (walk_end) begin
					state_nx = S_PUT;
				end
			end
			S_PUT: begin
				state_nx = S_DONE;
			end
			S_WALK_UP: begin
				if ((op_q == OP_SEARCH) && hit) begin
					state_nx = S_DONE;
				end else if (walk_end) begin
					state_nx = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || result_ready) begin
					state_nx = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	// RAM port controls. A walk reads one slot a cycle and writes the slot read
	// the cycle before to its neighbor, so read and write never meet on one slot.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = to_addr(idx_q);
		wr_en   = 1'b0;
		wr_addr = to_addr(tgt_q);
		wr_data = rdata_s1;
		case (state_q)
			S_WALK_DOWN: begin
				rd_en   = more_q;
				wr_en   = pend_q;
				wr_addr = to_addr(src_q + 7'd1);
			end
			S_PUT: begin
				wr_en   = 1'b1;
				wr_data = val_q;
			end
			S_WALK_UP: begin
				rd_en   = more_q;
				wr_en   = pend_q && (op_q == OP_REMOVE) && (src_q != tgt_q);
				wr_addr = to_addr(src_q - 7'd1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= 7'd0;
			cap_q       <= 7'd64;
			more_q      <= 1'b0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_wr) begin
				cap_q <= pwdata[6:0];
				cnt_q <= 7'd0;
			end
			case (state_q)
				S_DECODE: begin
					more_q <= 1'b1;
					pend_q <= 1'b0;
				end
				S_WALK_DOWN, S_WALK_UP: begin
					if (more_q) begin
						pend_q <= 1'b1;
						more_q <= (idx_q != end_q);
					end else begin
						pend_q <= 1'b0;
					end
					if ((state_q == S_WALK_UP) && (op_q == OP_REMOVE) && walk_end) begin
						cnt_q <= cnt_q - 7'd1;
					end
				end
				S_PUT: begin
					cnt_q <= cnt_q + 7'd1;
				end
				default: begin
				end
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload and walk pointers; no reset needed.
	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			op_q  <= operation;
			val_q <= item_value;
			pos_q <= position;
		end
		case (state_q)
			S_DECODE: begin
				tgt_q    <= dec_tgt;
				idx_q    <= dec_start;
				end_q    <= dec_stop;
				r_ok_q   <= 1'b0;
				r_val_q  <= '0;
				r_fpos_q <= 7'd0;
			end
			S_WALK_DOWN: begin
				if (more_q) begin
					src_q <= idx_q;
					idx_q <= idx_q - 7'd1;
				end
			end
			S_PUT: begin
				r_ok_q <= 1'b1;
			end
			S_WALK_UP: begin
				if (more_q) begin
					src_q <= idx_q;
					idx_q <= idx_q + 7'd1;
				end
				if (op_q == OP_SEARCH) begin
					if (hit) begin
						r_ok_q   <= 1'b1;
						r_fpos_q <= src_q + 7'd1;
					end
				end else begin
					if (pend_q && (src_q == tgt_q)) begin
						r_val_q <= rdata_s1;
					end
					if (walk_end) begin
						r_ok_q <= 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_ok_q   <= r_ok_q;
			out_val_q  <= r_val_q;
			out_fpos_q <= r_fpos_q;
			out_cnt_q  <= cnt_q;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/ale_checker.sv */
// Port-level checker of the array list engine and its bind to the top level.
`default_nettype none
`include "array_list_engine_top_defines.svh"

module ale_checker (
	input wire               clk,
	input wire               arst_n,
	input wire               item_valid,
	input wire               item_ready,
	input wire  [2:0]        operation,
	input wire  signed [31:0] item_value,
	input wire  [6:0]        position,
	input wire               result_valid,
	input wire               result_ready,
	input wire               ok,
	input wire  signed [31:0] value_out,
	input wire  [6:0]        found_position,
	input wire  [6:0]        count_out,
	input wire               psel,
	input wire               penable,
	input wire               pwrite,
	input wire  [2:0]        paddr,
	input wire  [31:0]       pwdata,
	input wire  [31:0]       prdata,
	input wire               pready
);

	// A stalled result beat keeps its payload.
	`ALE_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(ok) && $stable(value_out) && $stable(found_position) && $stable(count_out), "result beat changed while stalled")

	// A refused command reports no value and no position.
	`ALE_ASSERT_NOW(a_refused_zero, result_valid && !ok, (value_out == 32'sd0) && (found_position == 7'd0), "refused command carries data")

	// A search hit lies inside the list.
	`ALE_ASSERT_NOW(a_found_in_list, result_valid && (found_position != 7'd0), ok && (found_position <= count_out), "found position outside the list")

	// Commands are taken one at a time: a command beat closes the input until that command is done.
	`ALE_ASSERT_NEXT(a_one_at_a_time, item_valid && item_ready, !item_ready, "command taken while another is in work")

endmodule

bind array_list_engine_top ale_checker u_ale_checker (.*);

`default_nettype wire
